FILE: design/hpr_pkg.sv
// Shared constants for the horizontal polyphase resizer.
package hpr_pkg;

	localparam int MAX_TAPS_DEF    = 16;
	localparam int LINE_LENGTH_DEF = 2048;
	localparam int OUT_LENGTH_DEF  = 2048;

	localparam int COL_W   = 11;
	localparam int TAPI_W  = 4;
	localparam int PIX_W   = 16;
	localparam int COEF_W  = 16;
	localparam int RES_W   = 18;
	localparam int TAPS_W  = 5;
	localparam int SWID_W  = 12;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam int FRAC_SHIFT = 14;
	localparam int ROUND_BIAS = 8192;
	localparam int PIX_MAX    = 131071;
	localparam int PIX_MIN    = -131072;

	localparam int TAPS_RESET  = 4;
	localparam int SWID_RESET  = 2048;

	localparam logic [1:0] MODE_COEFF   = 2'd0;
	localparam logic [1:0] MODE_START   = 2'd1;
	localparam logic [1:0] MODE_PIXEL   = 2'd2;
	localparam logic [1:0] MODE_COMPUTE = 2'd3;

	localparam logic REG_TAPS  = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

endpackage

FILE: design/horizontal_polyphase_resize_top.sv
// Horizontal polyphase resizer: stores, register port and shared MAC sequencer.
// Load requests (coefficient, start column, pixel) complete without raising busy.
// A compute request holds busy while its N active taps are read, multiplied and summed;
// done strobes in the first cycle busy is low.
// The single multiply-accumulate unit takes one tap per cycle from single-port stores.
// arst_n clears control state and registers; stores hold undefined data until written.
module horizontal_polyphase_resize_top import hpr_pkg::*; #(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int LINE_LENGTH = LINE_LENGTH_DEF,
	parameter int OUT_LENGTH  = OUT_LENGTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               mode,
	input  logic [COL_W-1:0]         out_column,
	input  logic [TAPI_W-1:0]        tap_index,
	input  logic signed [COEF_W-1:0] coeff_value,
	input  logic [COL_W-1:0]         start_column,
	input  logic [COL_W-1:0]         src_column,
	input  logic [PIX_W-1:0]         pixel_value,
	output logic                     done,
	output logic [COL_W-1:0]         result_column,
	output logic signed [RES_W-1:0]  result_pixel,
	output logic                     saturated,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready
);

	localparam int CDEPTH  = OUT_LENGTH * MAX_TAPS;
	localparam int CA_W    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int OUT_AW  = $clog2(OUT_LENGTH);
	localparam int LINE_AW = $clog2(LINE_LENGTH);
	localparam int TAP_W   = $clog2(MAX_TAPS + 1);
	localparam int IDX_W   = (LINE_AW > SWID_W) ? LINE_AW : SWID_W;
	localparam int PROD_W  = COEF_W + PIX_W + 1;
	localparam int ACC_W   = PROD_W + TAP_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;

	localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(ROUND_BIAS);
	localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(PIX_MAX);
	localparam logic signed [ACC_W-1:0] ACC_MIN  = ACC_W'(PIX_MIN);

	logic [COEF_W-1:0] coeff_mem [CDEPTH];
	logic [COL_W-1:0]  start_mem [OUT_LENGTH];
	logic [PIX_W-1:0]  line_mem  [LINE_LENGTH];

	logic [TAPS_W-1:0] taps_q;
	logic [SWID_W-1:0] width_q;

	logic [1:0]               state_q;
	logic [CA_W-1:0]          cbase_q;
	logic [COL_W-1:0]         col_q;
	logic [TAP_W-1:0]         tap_q;
	logic [TAP_W-1:0]         ntaps_q;
	logic [IDX_W-1:0]         last_q;
	logic [COL_W-1:0]         first_q;
	logic [COEF_W-1:0]        coeff_rd_q;
	logic [PIX_W-1:0]         line_rd_q;
	logic                     valid_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic                     accept;
	logic                     cfg_wr;
	logic                     col_ok;
	logic [OUT_AW-1:0]        col_idx;
	logic [CA_W-1:0]          col_base;
	logic                     issue;
	logic                     finish;
	logic [IDX_W-1:0]         src_idx;
	logic [LINE_AW-1:0]       line_ra;
	logic [TAP_W-1:0]         ntaps;
	logic [IDX_W-1:0]         last_idx;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  rsh;
	int                       wid_lim;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_TAPS) ? APB_DW'(taps_q) : APB_DW'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q  <= TAPS_W'(TAPS_RESET);
			width_q <= SWID_W'(SWID_RESET);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_TAPS:  taps_q  <= pwdata[TAPS_W-1:0];
				REG_WIDTH: width_q <= pwdata[SWID_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign col_ok   = (32'(out_column) < OUT_LENGTH);
	assign col_idx  = OUT_AW'(out_column);
	assign col_base = CA_W'(32'(col_idx) * MAX_TAPS);

	always_comb begin
		ntaps = (32'(taps_q) > MAX_TAPS) ? TAP_W'(MAX_TAPS) : TAP_W'(taps_q);
		wid_lim = (32'(width_q) > LINE_LENGTH) ? LINE_LENGTH : 32'(width_q);
		if (wid_lim == 0) begin
			wid_lim = 1;
		end
		last_idx = IDX_W'(wid_lim - 1);
	end

	assign issue   = (state_q == ST_RUN) && (tap_q < ntaps_q);
	assign finish  = (state_q == ST_RUN) && !issue && !valid_s1 && !valid_s2;
	assign src_idx = IDX_W'(first_q) + IDX_W'(tap_q);
	assign line_ra = (src_idx > last_q) ? LINE_AW'(last_q) : LINE_AW'(src_idx);

	always_ff @(posedge clk) begin
		if (accept && mode == MODE_COEFF && col_ok && 32'(tap_index) < MAX_TAPS) begin
			coeff_mem[col_base + CA_W'(tap_index)] <= coeff_value;
		end
		if (issue) begin
			coeff_rd_q <= coeff_mem[cbase_q + CA_W'(tap_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mode == MODE_START && col_ok) begin
			start_mem[col_idx] <= start_column;
		end
		if (accept && mode == MODE_COMPUTE && col_ok) begin
			first_q <= start_mem[col_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mode == MODE_PIXEL && 32'(src_column) < LINE_LENGTH) begin
			line_mem[LINE_AW'(src_column)] <= pixel_value;
		end
		if (issue) begin
			line_rd_q <= line_mem[line_ra];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(coeff_rd_q) * $signed({1'b0, line_rd_q});
	end

	assign rnd = acc_q + ACC_BIAS;
	assign rsh = rnd >>> FRAC_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cbase_q       <= '0;
			col_q         <= '0;
			tap_q         <= '0;
			ntaps_q       <= '0;
			last_q        <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			acc_q         <= '0;
			done          <= 1'b0;
			result_column <= '0;
			result_pixel  <= '0;
			saturated     <= 1'b0;
		end else begin
			done     <= 1'b0;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && mode == MODE_COMPUTE && col_ok) begin
						state_q <= ST_RUN;
						cbase_q <= col_base;
						col_q   <= out_column;
						tap_q   <= '0;
						ntaps_q <= ntaps;
						last_q  <= last_idx;
						acc_q   <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						tap_q <= tap_q + 1'b1;
					end
					if (valid_s2) begin
						acc_q <= acc_q + ACC_W'(prod_s2);
					end
					if (finish) begin
						state_q       <= ST_IDLE;
						done          <= 1'b1;
						result_column <= col_q;
						if (rsh > ACC_MAX) begin
							result_pixel <= RES_W'(ACC_MAX);
							saturated    <= 1'b1;
						end else if (rsh < ACC_MIN) begin
							result_pixel <= RES_W'(ACC_MIN);
							saturated    <= 1'b1;
						end else begin
							result_pixel <= RES_W'(rsh);
							saturated    <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: design/hpr_checker.sv
// Port-level checker for the horizontal polyphase resizer, bound to the top level.
module hpr_checker import hpr_pkg::*; #(
	parameter int OUT_LENGTH = OUT_LENGTH_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [1:0]       mode,
	input logic [COL_W-1:0] out_column,
	input logic             done,
	input logic             pready
);

	logic compute_req;

	assign compute_req = start && !busy && mode == MODE_COMPUTE && 32'(out_column) < OUT_LENGTH;

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		compute_req |=> busy)
		else $error("compute request did not raise busy");

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode != MODE_COMPUTE) |=> !busy)
		else $error("load request raised busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("done strobe outside end of compute");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind horizontal_polyphase_resize_top hpr_checker #(
	.OUT_LENGTH(OUT_LENGTH)
) u_hpr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.mode(mode),
	.out_column(out_column),
	.done(done),
	.pready(pready)
);

FILE: test/tb_top.sv
// Testbench for the horizontal polyphase resizer: directed, corner and random requests.
`timescale 1ns / 100ps

module tb_top;
	import hpr_pkg::*;

	localparam int MAX_TAPS    = MAX_TAPS_DEF;
	localparam int LINE_LENGTH = LINE_LENGTH_DEF;
	localparam int OUT_LENGTH  = OUT_LENGTH_DEF;
	localparam int SETTLE      = MAX_TAPS + 8;

	typedef struct {
		logic [1:0]               mode;
		logic [COL_W-1:0]         col;
		logic [TAPI_W-1:0]        tap;
		logic signed [COEF_W-1:0] coef;
		logic [COL_W-1:0]         first;
		logic [COL_W-1:0]         scol;
		logic [PIX_W-1:0]         pix;
	} hpr_req_t;

	typedef struct {
		logic [COL_W-1:0]        col;
		logic signed [RES_W-1:0] pix;
		logic                    sat;
	} hpr_pixel_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               mode = MODE_COEFF;
	logic [COL_W-1:0]         out_column = '0;
	logic [TAPI_W-1:0]        tap_index = '0;
	logic signed [COEF_W-1:0] coeff_value = '0;
	logic [COL_W-1:0]         start_column = '0;
	logic [COL_W-1:0]         src_column = '0;
	logic [PIX_W-1:0]         pixel_value = '0;
	logic                     done;
	logic [COL_W-1:0]         result_column;
	logic signed [RES_W-1:0]  result_pixel;
	logic                     saturated;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_AW-1:0]        paddr = '0;
	logic [APB_DW-1:0]        pwdata = '0;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;

	// Shadow of the block's stores and registers
	logic signed [COEF_W-1:0] coeff_mem [OUT_LENGTH][MAX_TAPS];
	bit                       coeff_ok  [OUT_LENGTH][MAX_TAPS];
	logic [COL_W-1:0]         start_mem [OUT_LENGTH];
	bit                       start_ok  [OUT_LENGTH];
	logic [PIX_W-1:0]         line_mem  [LINE_LENGTH];
	bit                       line_ok   [LINE_LENGTH];
	bit                       listed    [OUT_LENGTH];
	logic [TAPS_W-1:0]        taps_reg = TAPS_W'(TAPS_RESET);
	logic [SWID_W-1:0]        width_reg = SWID_W'(SWID_RESET);

	hpr_pixel_t pending_pixels[$];
	int         ready_cols[$];
	bit         gaps_on = 1'b1;
	int         n_errors = 0;
	int         n_requests = 0;
	int         n_checked = 0;
	int         n_clipped = 0;
	int         n_settings = 0;

	horizontal_polyphase_resize_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .out_column(out_column), .tap_index(tap_index),
		.coeff_value(coeff_value), .start_column(start_column),
		.src_column(src_column), .pixel_value(pixel_value),
		.done(done), .result_column(result_column), .result_pixel(result_pixel),
		.saturated(saturated),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(64'd12_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int active_taps();
		return (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
	endfunction

	function automatic int last_column();
		int w;
		w = (width_reg > LINE_LENGTH) ? LINE_LENGTH : int'(width_reg);
		if (w == 0) begin
			w = 1;
		end
		return w - 1;
	endfunction

	function automatic hpr_pixel_t predict_pixel(int col);
		longint     acc;
		longint     r;
		int         s;
		hpr_pixel_t res;
		acc = 0;
		for (int t = 0; t < active_taps(); t++) begin
			s = int'(start_mem[col]) + t;
			if (s > last_column()) begin
				s = last_column();
			end
			acc += longint'(coeff_mem[col][t]) * longint'(line_mem[s]);
		end
		r = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
		res.sat = 1'b0;
		if (r > PIX_MAX) begin
			r = PIX_MAX;
			res.sat = 1'b1;
		end else if (r < PIX_MIN) begin
			r = PIX_MIN;
			res.sat = 1'b1;
		end
		res.col = COL_W'(col);
		res.pix = r[RES_W-1:0];
		return res;
	endfunction

	function automatic hpr_req_t noise_req(logic [1:0] m);
		hpr_req_t rq;
		rq.mode  = m;
		rq.col   = COL_W'($urandom);
		rq.tap   = TAPI_W'($urandom);
		rq.coef  = COEF_W'($urandom);
		rq.first = COL_W'($urandom);
		rq.scol  = COL_W'($urandom);
		rq.pix   = PIX_W'($urandom);
		return rq;
	endfunction

	function automatic int pick_start();
		int v;
		case ($urandom_range(0, 3))
			0: v = LINE_LENGTH - 1 - $urandom_range(0, 15);
			1: begin
				v = last_column() - int'($urandom_range(0, 15));
				if (v < 0) begin
					v = 0;
				end
			end
			default: v = $urandom_range(0, 2047);
		endcase
		return v;
	endfunction

	function automatic logic signed [COEF_W-1:0] pick_coeff();
		logic signed [COEF_W-1:0] c;
		case ($urandom_range(0, 7))
			0: c = 16'sh7FFF;
			1: c = 16'sh8000;
			2, 3: c = COEF_W'(int'($urandom_range(0, 128)) - 64);
			default: c = COEF_W'($urandom);
		endcase
		return c;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] p;
		case ($urandom_range(0, 7))
			0: p = '0;
			1: p = '1;
			2: p = PIX_W'(8192);
			default: p = PIX_W'($urandom);
		endcase
		return p;
	endfunction

	function automatic int pick_src();
		int s;
		if (ready_cols.size() != 0 && $urandom_range(0, 1) == 1) begin
			s = int'(start_mem[ready_cols[$urandom_range(0, ready_cols.size() - 1)]])
				+ $urandom_range(0, 15);
			if (s > LINE_LENGTH - 1) begin
				s = LINE_LENGTH - 1;
			end
		end else begin
			s = $urandom_range(0, LINE_LENGTH - 1);
		end
		return s;
	endfunction

	function automatic int pick_taps();
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = $urandom_range(17, 31);
			default: v = $urandom_range(1, 16);
		endcase
		return v;
	endfunction

	function automatic int pick_width();
		int v;
		case ($urandom_range(0, 19))
			0: v = 0;
			1: v = $urandom_range(2049, 4095);
			2, 3, 4: v = 2048;
			5, 6, 7, 8, 9: v = $urandom_range(1, 32);
			default: v = $urandom_range(1, 2048);
		endcase
		return v;
	endfunction

	// Drive one request, wait for acceptance, then update the shadow state.
	task automatic send_request(input hpr_req_t rq);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start        <= 1'b1;
		mode         <= rq.mode;
		out_column   <= rq.col;
		tap_index    <= rq.tap;
		coeff_value  <= rq.coef;
		start_column <= rq.first;
		src_column   <= rq.scol;
		pixel_value  <= rq.pix;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_requests++;
		case (rq.mode)
			MODE_COEFF: begin
				coeff_mem[rq.col][rq.tap] = rq.coef;
				coeff_ok[rq.col][rq.tap]  = 1'b1;
			end
			MODE_START: begin
				start_mem[rq.col] = rq.first;
				start_ok[rq.col]  = 1'b1;
			end
			MODE_PIXEL: begin
				line_mem[rq.scol] = rq.pix;
				line_ok[rq.scol]  = 1'b1;
			end
			default: pending_pixels.push_back(predict_pixel(int'(rq.col)));
		endcase
	endtask

	task automatic load_coeff(input int col, input int tap, input logic signed [COEF_W-1:0] c);
		hpr_req_t rq;
		rq      = noise_req(MODE_COEFF);
		rq.col  = COL_W'(col);
		rq.tap  = TAPI_W'(tap);
		rq.coef = c;
		send_request(rq);
	endtask

	task automatic load_start_col(input int col, input int first);
		hpr_req_t rq;
		rq       = noise_req(MODE_START);
		rq.col   = COL_W'(col);
		rq.first = COL_W'(first);
		send_request(rq);
	endtask

	task automatic load_pixel(input int scol, input logic [PIX_W-1:0] p);
		hpr_req_t rq;
		rq      = noise_req(MODE_PIXEL);
		rq.scol = COL_W'(scol);
		rq.pix  = p;
		send_request(rq);
	endtask

	// Fill whatever the column still lacks, then request its output pixel.
	task automatic filter_column(input int col);
		hpr_req_t rq;
		int       s;
		if (!start_ok[col]) begin
			load_start_col(col, pick_start());
		end
		for (int t = 0; t < active_taps(); t++) begin
			if (!coeff_ok[col][t]) begin
				load_coeff(col, t, pick_coeff());
			end
		end
		for (int t = 0; t < active_taps(); t++) begin
			s = int'(start_mem[col]) + t;
			if (s > last_column()) begin
				s = last_column();
			end
			if (!line_ok[s]) begin
				load_pixel(s, pick_pixel());
			end
		end
		rq     = noise_req(MODE_COMPUTE);
		rq.col = COL_W'(col);
		send_request(rq);
		if (!listed[col]) begin
			listed[col] = 1'b1;
			ready_cols.push_back(col);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (idx == REG_TAPS) begin
			taps_reg = TAPS_W'(value);
		end else begin
			width_reg = SWID_W'(value);
		end
	endtask

	task automatic set_config(input int taps, input int width);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		write_register(REG_TAPS, taps);
		write_register(REG_WIDTH, width);
		n_settings++;
	endtask

	task automatic test_directed_extremes();
		for (int s = 0; s < 4; s++) begin
			load_pixel(s, '1);
		end
		load_pixel(LINE_LENGTH - 1, '1);
		load_start_col(0, 0);
		for (int t = 0; t < 4; t++) begin
			load_coeff(0, t, 16'sh7FFF);
		end
		filter_column(0);
		// clamp every tap to the last source column, clip low
		load_start_col(OUT_LENGTH - 1, LINE_LENGTH - 1);
		for (int t = 0; t < 4; t++) begin
			load_coeff(OUT_LENGTH - 1, t, 16'sh8000);
		end
		filter_column(OUT_LENGTH - 1);
		// exact half rounds up
		load_pixel(0, PIX_W'(8192));
		load_coeff(0, 0, 16'sh0001);
		for (int t = 1; t < 4; t++) begin
			load_coeff(0, t, '0);
		end
		filter_column(0);
	endtask

	task automatic test_register_corners();
		int taps_list[8]  = '{0, 1, 16, 17, 31, 16, 4, 2};
		int width_list[8] = '{2048, 1, 0, 4095, 2048, 2048, 5, 17};
		for (int i = 0; i < 8; i++) begin
			set_config(taps_list[i], width_list[i]);
			filter_column(0);
			filter_column(OUT_LENGTH - 1);
			filter_column($urandom_range(0, OUT_LENGTH - 1));
			filter_column($urandom_range(0, OUT_LENGTH - 1));
		end
	endtask

	task automatic test_random_traffic(input int count, input bit idle_ok);
		int target;
		int next_cfg;
		int kind;
		int col;
		target   = n_requests + count;
		next_cfg = n_requests;
		gaps_on  = idle_ok;
		while (n_requests < target) begin
			if (n_requests >= next_cfg) begin
				set_config(pick_taps(), pick_width());
				gaps_on  = idle_ok && ($urandom_range(0, 3) != 0);
				next_cfg = n_requests + 150;
			end
			kind = $urandom_range(0, 99);
			col  = (ready_cols.size() != 0) ?
				ready_cols[$urandom_range(0, ready_cols.size() - 1)] : 0;
			if (kind < 45 && ready_cols.size() != 0) begin
				filter_column(col);
			end else if (kind < 55) begin
				filter_column($urandom_range(0, OUT_LENGTH - 1));
			end else if (kind < 75) begin
				load_pixel(pick_src(), pick_pixel());
			end else if (kind < 90 && ready_cols.size() != 0) begin
				load_coeff(col, $urandom_range(0, MAX_TAPS - 1), pick_coeff());
			end else if (kind < 96 && ready_cols.size() != 0) begin
				load_start_col(col, pick_start());
			end else if (idle_ok) begin
				drain_results();
			end else begin
				load_pixel(pick_src(), pick_pixel());
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		hpr_pixel_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				$error("result_column %0d arrived with no request pending", result_column);
				n_errors++;
			end else begin
				want = pending_pixels.pop_front();
				n_checked++;
				if (want.sat) begin
					n_clipped++;
				end
				if (result_column !== want.col) begin
					$error("result_column: expected %0d, got %0d", want.col, result_column);
					n_errors++;
				end
				if (result_pixel !== want.pix) begin
					$error("result_pixel: expected %0d, got %0d", want.pix, result_pixel);
					n_errors++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %0d, got %0d", want.sat, saturated);
					n_errors++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_register_corners();
		test_random_traffic(500, 1'b1);
		test_random_traffic(100, 1'b0);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d requests over %0d register settings (taps 0..31, widths 0..4095).",
			n_requests, n_settings);
		$display("Checked %0d filtered pixels, %0d of them clipped.", n_checked, n_clipped);
		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/hpr_pkg.sv
design/horizontal_polyphase_resize_top.sv
design/hpr_checker.sv
test/tb_top.sv
